/* rtl/core/hcv_pkg.sv */
// ----------------------------------------------------------------------------
// hcv_pkg
// Shared constants, item types, trig table and address helpers for the
// circle hough voter.
// ----------------------------------------------------------------------------
package hcv_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int RADIUS_COUNT = 16;
  localparam int ANGLE_STEPS  = 360;

  localparam int FULL_TURN    = 360;
  localparam int HALF_TURN    = 180;
  localparam int QUARTER_TURN = 90;
  localparam int THREE_QUARTER_TURN = 270;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * RADIUS_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int RIDX_W      = (RADIUS_COUNT > 1) ? $clog2(RADIUS_COUNT) : 1;
  localparam int ANGLE_W     = $clog2(ANGLE_STEPS);
  localparam int REM_W       = $clog2(ANGLE_STEPS) + 1;
  localparam int DEG_W       = 9;
  localparam int DEG_STEP    = FULL_TURN / ANGLE_STEPS;
  localparam int DEG_REM     = FULL_TURN % ANGLE_STEPS;

  localparam int PIX_W    = 8;
  localparam int RADIUS_W = 9;
  localparam int COORD_W  = 14;
  localparam int CNT_W    = 16;
  localparam int TRIG_W   = 17;
  localparam int PROD_W   = RADIUS_W + TRIG_W;
  localparam int FRAC_W   = 16;
  localparam int V_W      = PROD_W + 2;

  localparam int FRAME_W   = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_VOTE_THRESHOLD = CFG_IDX_W'(3);

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST    = FRAME_W'(256);
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST   = FRAME_W'(256);
  localparam logic [7:0]         MIN_RADIUS_RST     = 8'd50;
  localparam logic [CNT_W-1:0]   VOTE_THRESHOLD_RST = CNT_W'(100);

  localparam logic           OP_VOTE   = 1'b0;
  localparam logic           OP_REPORT = 1'b1;
  localparam logic [7:0]     EDGE_ON   = 8'd255;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int SINE_Q16 [91] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62673, 62997, 63303, 63590, 63856, 64104, 64332,
    64540, 64729, 64899, 65048, 65177, 65286, 65374, 65442, 65492, 65526,
    65536
  };

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [7:0]       edge_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]    center_x;
    logic [PIX_W-1:0]    center_y;
    logic [RADIUS_W-1:0] radius;
    logic [CNT_W-1:0]    vote_count;
    logic                found;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic              neg;
    logic [TRIG_W-1:0] mag;
  } trig_t;

  typedef struct packed {
    logic                valid;
    logic [PIX_W-1:0]    px;
    logic [PIX_W-1:0]    py;
    logic [RADIUS_W-1:0] radius;
    logic [RIDX_W-1:0]   ridx;
    logic [DEG_W-1:0]    deg;
  } center_req_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } center_rsp_t;

  function automatic trig_t sin_deg(input logic [DEG_W-1:0] d);
    trig_t            t;
    logic [DEG_W-1:0] k;
    if (d <= DEG_W'(QUARTER_TURN)) begin
      k     = d;
      t.neg = 1'b0;
    end else if (d <= DEG_W'(HALF_TURN)) begin
      k     = DEG_W'(HALF_TURN) - d;
      t.neg = 1'b0;
    end else if (d <= DEG_W'(THREE_QUARTER_TURN)) begin
      k     = d - DEG_W'(HALF_TURN);
      t.neg = 1'b1;
    end else begin
      k     = DEG_W'(FULL_TURN) - d;
      t.neg = 1'b1;
    end
    t.mag = TRIG_W'(SINE_Q16[k[6:0]]);
    return t;
  endfunction

  function automatic trig_t cos_deg(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0] dc;
    if (d >= DEG_W'(THREE_QUARTER_TURN)) begin
      dc = d - DEG_W'(THREE_QUARTER_TURN);
    end else begin
      dc = d + DEG_W'(QUARTER_TURN);
    end
    return sin_deg(dc);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b,
                                                   input logic [RIDX_W-1:0]  ri);
    return ADDR_W'((ADDR_W'(b) * ADDR_W'(MAX_WIDTH) + ADDR_W'(a)) * ADDR_W'(RADIUS_COUNT)
                   + ADDR_W'(ri));
  endfunction

endpackage

/* rtl/core/hcv_ram.sv */
// ----------------------------------------------------------------------------
// hcv_ram
// Generic simple dual port ram, one write and one registered read port,
// read returns old data on a same-address write.
// ----------------------------------------------------------------------------
module hcv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

/* rtl/core/hcv_center.sv */
// ----------------------------------------------------------------------------
// hcv_center
// Shared center unit: trig lookup and radius products, truncating center
// coordinates with frame check, then accumulator address. Three stages.
// ----------------------------------------------------------------------------
module hcv_center import hcv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  center_req_t        req,
  input  logic [COORD_W-1:0] wlim,
  input  logic [COORD_W-1:0] hlim,
  output center_rsp_t        rsp,
  output logic               busy
);

  function automatic logic signed [COORD_W-1:0] center_coord(
      input logic [PIX_W-1:0] p, input logic [PROD_W-1:0] prod, input logic neg);
    logic signed [V_W-1:0] base;
    logic signed [V_W-1:0] term;
    logic signed [V_W-1:0] v;
    logic signed [V_W-1:0] vb;
    base = signed'(V_W'({p, {FRAC_W{1'b0}}}));
    term = signed'(V_W'(prod));
    v    = neg ? base + term : base - term;
    vb   = v + signed'({{(V_W-FRAC_W){1'b0}}, {FRAC_W{v[V_W-1]}}});
    return signed'(COORD_W'(vb >>> FRAC_W));
  endfunction

  trig_t cos_v;
  trig_t sin_v;

  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_px_r;
  logic [PIX_W-1:0]  s1_py_r;
  logic [RIDX_W-1:0] s1_ridx_r;
  logic [PROD_W-1:0] s1_prod_a_r;
  logic [PROD_W-1:0] s1_prod_b_r;
  logic              s1_neg_a_r;
  logic              s1_neg_b_r;

  logic signed [COORD_W-1:0] coord_a;
  logic signed [COORD_W-1:0] coord_b;
  logic                      hit;

  logic               s2_valid_r;
  logic               s2_hit_r;
  logic [COORD_W-1:0] s2_a_r;
  logic [COORD_W-1:0] s2_b_r;
  logic [RIDX_W-1:0]  s2_ridx_r;

  logic              s3_valid_r;
  logic              s3_hit_r;
  logic [ADDR_W-1:0] s3_addr_r;

  assign cos_v = cos_deg(req.deg);
  assign sin_v = sin_deg(req.deg);

  assign coord_a = center_coord(s1_px_r, s1_prod_a_r, s1_neg_a_r);
  assign coord_b = center_coord(s1_py_r, s1_prod_b_r, s1_neg_b_r);
  assign hit = (coord_a >= 0) && (coord_a < signed'(wlim)) &&
               (coord_b >= 0) && (coord_b < signed'(hlim));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_px_r     <= req.px;
    s1_py_r     <= req.py;
    s1_ridx_r   <= req.ridx;
    s1_prod_a_r <= PROD_W'(req.radius) * PROD_W'(cos_v.mag);
    s1_prod_b_r <= PROD_W'(req.radius) * PROD_W'(sin_v.mag);
    s1_neg_a_r  <= cos_v.neg;
    s1_neg_b_r  <= sin_v.neg;

    s2_hit_r  <= hit;
    s2_a_r    <= coord_a;
    s2_b_r    <= coord_b;
    s2_ridx_r <= s1_ridx_r;

    s3_hit_r  <= s2_hit_r;
    s3_addr_r <= store_addr(s2_a_r, s2_b_r, s2_ridx_r);
  end

  assign rsp  = '{valid: s3_valid_r, hit: s3_hit_r, addr: s3_addr_r};
  assign busy = s1_valid_r | s2_valid_r | s3_valid_r;

endmodule

/* rtl/core/hough_circle_voter.sv */
// ----------------------------------------------------------------------------
// hough_circle_voter
// Vote item with edge 255: 16 radii x 360 angles = 5760 center requests, one
// counter read-modify-write per cycle through the shared center unit, then a
// drain state. Other votes are dropped. Report item: 16 results, each read,
// captured and output, held while out_stall is high. After reset a clearing
// pass writes all 1048576 counters to zero, one per cycle, before any item is
// accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module hough_circle_voter import hcv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_VOTE     = 7'b0000100,
    ST_DRAIN    = 7'b0001000,
    ST_REP_READ = 7'b0010000,
    ST_REP_CAP  = 7'b0100000,
    ST_REP_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [FRAME_W-1:0] frame_width_r;
  logic [FRAME_W-1:0] frame_height_r;
  logic [7:0]         min_radius_r;
  logic [CNT_W-1:0]   vote_threshold_r;

  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [PIX_W-1:0]   vx_r, vx_nxt;
  logic [PIX_W-1:0]   vy_r, vy_nxt;
  logic [RIDX_W-1:0]  ridx_r, ridx_nxt;
  logic [ANGLE_W-1:0] ang_r, ang_nxt;
  logic [DEG_W-1:0]   deg_r, deg_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [REM_W-1:0]   rem_sum;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               rmw_valid_r;
  logic [ADDR_W-1:0]  rmw_addr_r;
  logic               wr_valid_r;
  logic [ADDR_W-1:0]  wr_addr_r;
  logic [CNT_W-1:0]   wr_data_r;

  center_req_t        req;
  center_rsp_t        rsp;
  logic               center_busy;
  logic [COORD_W-1:0] wlim;
  logic [COORD_W-1:0] hlim;
  logic [COORD_W-1:0] fw_ext;
  logic [COORD_W-1:0] fh_ext;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CNT_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CNT_W-1:0]   ram_rdata;

  logic [CNT_W-1:0]   cur_cnt;
  logic [CNT_W-1:0]   inc_cnt;
  logic               rep_in_store;
  logic [ADDR_W-1:0]  rep_addr;
  logic [CNT_W-1:0]   rep_cnt;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= FRAME_WIDTH_RST;
      frame_height_r   <= FRAME_HEIGHT_RST;
      min_radius_r     <= MIN_RADIUS_RST;
      vote_threshold_r <= VOTE_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    frame_width_r    <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT:   frame_height_r   <= cfg_data[FRAME_W-1:0];
        REG_MIN_RADIUS:     min_radius_r     <= cfg_data[7:0];
        REG_VOTE_THRESHOLD: vote_threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fw_ext = COORD_W'(frame_width_r);
  assign fh_ext = COORD_W'(frame_height_r);
  assign wlim = (fw_ext < COORD_W'(MAX_WIDTH))  ? fw_ext : COORD_W'(MAX_WIDTH);
  assign hlim = (fh_ext < COORD_W'(MAX_HEIGHT)) ? fh_ext : COORD_W'(MAX_HEIGHT);

  // center unit
  assign req = '{valid:  (state_r == ST_VOTE),
                 px:     vx_r,
                 py:     vy_r,
                 radius: RADIUS_W'(min_radius_r) + RADIUS_W'(ridx_r),
                 ridx:   ridx_r,
                 deg:    deg_r};

  hcv_center u_center (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .wlim  (wlim),
    .hlim  (hlim),
    .rsp   (rsp),
    .busy  (center_busy)
  );

  // report addressing
  assign rep_in_store = (COORD_W'(vx_r) < COORD_W'(MAX_WIDTH)) &&
                        (COORD_W'(vy_r) < COORD_W'(MAX_HEIGHT));
  assign rep_addr = store_addr(COORD_W'(vx_r), COORD_W'(vy_r), ridx_r);
  assign rep_cnt  = rep_in_store ? ram_rdata : '0;

  // counter update with forward of the previous write
  assign cur_cnt = (wr_valid_r && (wr_addr_r == rmw_addr_r)) ? wr_data_r : ram_rdata;
  assign inc_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);

  always_comb begin
    if (state_r == ST_REP_READ) begin
      ram_re    = rep_in_store;
      ram_raddr = rep_addr;
    end else begin
      ram_re    = rsp.valid && rsp.hit;
      ram_raddr = rsp.addr;
    end
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_REP_CAP: begin
        ram_we    = rep_in_store;
        ram_waddr = rep_addr;
        ram_wdata = '0;
      end
      default: begin
        ram_we    = rmw_valid_r;
        ram_waddr = rmw_addr_r;
        ram_wdata = inc_cnt;
      end
    endcase
  end

  hcv_ram #(
    .WIDTH (CNT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // sequencer
  assign rem_sum = rem_r + REM_W'(DEG_REM);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    ridx_nxt      = ridx_r;
    ang_nxt       = ang_r;
    deg_nxt       = deg_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          vx_nxt   = in_data.pixel_x;
          vy_nxt   = in_data.pixel_y;
          ridx_nxt = '0;
          ang_nxt  = '0;
          deg_nxt  = '0;
          rem_nxt  = '0;
          if (in_data.operation == OP_REPORT) begin
            state_nxt = ST_REP_READ;
          end else if (in_data.edge_value == EDGE_ON) begin
            state_nxt = ST_VOTE;
          end
        end
      end
      ST_VOTE: begin
        if (ang_r == ANGLE_W'(ANGLE_STEPS - 1)) begin
          ang_nxt = '0;
          deg_nxt = '0;
          rem_nxt = '0;
          if (ridx_r == RIDX_W'(RADIUS_COUNT - 1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            ridx_nxt = ridx_r + RIDX_W'(1);
          end
        end else begin
          ang_nxt = ang_r + ANGLE_W'(1);
          if (rem_sum >= REM_W'(ANGLE_STEPS)) begin
            rem_nxt = rem_sum - REM_W'(ANGLE_STEPS);
            deg_nxt = deg_r + DEG_W'(DEG_STEP + 1);
          end else begin
            rem_nxt = rem_sum;
            deg_nxt = deg_r + DEG_W'(DEG_STEP);
          end
        end
      end
      ST_DRAIN: begin
        if (!center_busy && !rmw_valid_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REP_READ: begin
        state_nxt = ST_REP_CAP;
      end
      ST_REP_CAP: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.center_x   = vx_r;
        out_data_nxt.center_y   = vy_r;
        out_data_nxt.radius     = RADIUS_W'(min_radius_r) + RADIUS_W'(ridx_r);
        out_data_nxt.vote_count = rep_cnt;
        out_data_nxt.found      = rep_cnt > vote_threshold_r;
        out_data_nxt.last       = (ridx_r == RIDX_W'(RADIUS_COUNT - 1));
        state_nxt               = ST_REP_OUT;
      end
      ST_REP_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (ridx_r == RIDX_W'(RADIUS_COUNT - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            ridx_nxt  = ridx_r + RIDX_W'(1);
            state_nxt = ST_REP_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      ridx_r      <= '0;
      ang_r       <= '0;
      deg_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      rmw_valid_r <= 1'b0;
      wr_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ridx_r      <= ridx_nxt;
      ang_r       <= ang_nxt;
      deg_r       <= deg_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      rmw_valid_r <= rsp.valid && rsp.hit;
      wr_valid_r  <= rmw_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    out_data_r <= out_data_nxt;
    rmw_addr_r <= rsp.addr;
    wr_addr_r  <= rmw_addr_r;
    wr_data_r  <= inc_cnt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/hcv_checker.sv */
// ----------------------------------------------------------------------------
// hcv_checker
// Port level checks for the circle hough voter, bound to the top level.
// ----------------------------------------------------------------------------
module hcv_checker import hcv_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // ready for input only with no result pending
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input ready while result pending");

  // accepted report item makes the block busy
  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == OP_REPORT) |=> in_stall)
    else $error("report item did not start");

  // more results follow a non-final one
  a_report_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> in_stall)
    else $error("report ended early");

  // nothing follows the final result of a report
  a_report_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid)
    else $error("result item after last");

endmodule

bind hough_circle_voter hcv_checker u_hcv_checker (.*);

/* verif/tb_hough_circle_voter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hough_circle_voter
// Self-checking bench for the circle hough voter. A software tally of the
// full counter store is updated on every accepted edge vote and drained on every
// accepted report. Each report result is compared field by field with the
// oldest predicted row. Directed tests cover register defaults, radius zero,
// threshold edges, frame bounds and a long output hold-off, then random
// traffic runs in phases with and without idle cycles and output stalls.
// ----------------------------------------------------------------------------
module tb_hough_circle_voter;
  import hcv_pkg::*;

  localparam int CYCLE_LIMIT     = 6_000_000;
  localparam int VOTE_LATENCY    = RADIUS_COUNT * ANGLE_STEPS + 64;
  localparam int ITEMS_PER_PHASE = 18;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int PIXEL_HISTORY   = 8;
  localparam int PIXEL_MAX       = 255;
  localparam int IDLE_PLAN [4]   = '{0, 63, 0, 12};
  localparam int STALL_PLAN [4]  = '{0, 0, 63, 12};

  localparam int SINE_QUARTER [91] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62673, 62997, 63303, 63590, 63856, 64104, 64332,
    64540, 64729, 64899, 65048, 65177, 65286, 65374, 65442, 65492, 65526,
    65536
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit [CNT_W-1:0]     vote_tally [STORE_DEPTH];
  logic [FRAME_W-1:0] width_setting  = FRAME_WIDTH_RST;
  logic [FRAME_W-1:0] height_setting = FRAME_HEIGHT_RST;
  logic [7:0]         rmin_setting   = MIN_RADIUS_RST;
  logic [CNT_W-1:0]   thr_setting    = VOTE_THRESHOLD_RST;

  out_item_t          report_rows [$];
  logic [2*PIX_W-1:0] voted_pixels [$];
  out_item_t          head_row;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  hough_circle_voter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int sine_of(int deg);
    int d;
    d = deg % FULL_TURN;
    if (d <= QUARTER_TURN) return SINE_QUARTER[d];
    if (d <= HALF_TURN) return SINE_QUARTER[HALF_TURN - d];
    if (d <= THREE_QUARTER_TURN) return -SINE_QUARTER[d - HALF_TURN];
    return -SINE_QUARTER[FULL_TURN - d];
  endfunction

  // truncate toward zero after dropping the q16 fraction
  function automatic int shift_center(int p, int r, int trig);
    longint v;
    v = longint'(p) * 65536 - longint'(r) * longint'(trig);
    if (v >= 0) return int'(v >>> FRAC_W);
    return -int'((-v) >>> FRAC_W);
  endfunction

  function automatic in_item_t make_item(logic op, int x, int y, int value);
    in_item_t item;
    item.operation  = op;
    item.pixel_x    = PIX_W'(x);
    item.pixel_y    = PIX_W'(y);
    item.edge_value = 8'(value);
    return item;
  endfunction

  function automatic void tally_item(in_item_t item);
    int wlim, hlim, r, a, b, idx, deg;
    logic [CNT_W-1:0] count;
    out_item_t row;
    if (item.operation == OP_VOTE) begin
      if (item.edge_value != EDGE_ON) return;
      wlim = (width_setting < MAX_WIDTH) ? int'(width_setting) : MAX_WIDTH;
      hlim = (height_setting < MAX_HEIGHT) ? int'(height_setting) : MAX_HEIGHT;
      for (int i = 0; i < RADIUS_COUNT; i++) begin
        r = int'(rmin_setting) + i;
        for (int t = 0; t < ANGLE_STEPS; t++) begin
          deg = t * FULL_TURN / ANGLE_STEPS;
          a = shift_center(int'(item.pixel_x), r, sine_of(deg + QUARTER_TURN));
          b = shift_center(int'(item.pixel_y), r, sine_of(deg));
          if (a >= 0 && a < wlim && b >= 0 && b < hlim) begin
            idx = (b * MAX_WIDTH + a) * RADIUS_COUNT + i;
            if (vote_tally[idx] != CNT_MAX) vote_tally[idx]++;
          end
        end
      end
    end else begin
      for (int i = 0; i < RADIUS_COUNT; i++) begin
        idx = (int'(item.pixel_y) * MAX_WIDTH + int'(item.pixel_x)) * RADIUS_COUNT + i;
        count = vote_tally[idx];
        vote_tally[idx] = '0;
        row.center_x   = item.pixel_x;
        row.center_y   = item.pixel_y;
        row.radius     = RADIUS_W'(int'(rmin_setting) + i);
        row.vote_count = count;
        row.found      = (count > thr_setting);
        row.last       = (i == RADIUS_COUNT - 1);
        report_rows.push_back(row);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_item(in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    tally_item(item);
    if (item.operation == OP_VOTE && item.edge_value == EDGE_ON) begin
      voted_pixels.push_back({item.pixel_x, item.pixel_y});
      if (voted_pixels.size() > PIXEL_HISTORY) void'(voted_pixels.pop_front());
    end
  endtask

  // wait for every result, then for a full vote pass that may still run
  task automatic settle_block();
    in_valid <= 1'b0;
    while (report_rows.size() != 0) @(posedge clk);
    repeat (VOTE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_FRAME_WIDTH:    width_setting  = data[FRAME_W-1:0];
      REG_FRAME_HEIGHT:   height_setting = data[FRAME_W-1:0];
      REG_MIN_RADIUS:     rmin_setting   = data[7:0];
      REG_VOTE_THRESHOLD: thr_setting    = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [FRAME_W-1:0] fw, logic [FRAME_W-1:0] fh,
                              logic [7:0] rmin, logic [CNT_W-1:0] thr);
    logic [CFG_DATA_W-1:0] noise;
    settle_block();
    noise = $urandom;
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_VOTE_THRESHOLD) + 1, (1 << CFG_IDX_W) - 1)),
              noise);
    noise = $urandom;
    write_reg(REG_FRAME_WIDTH, {noise[CFG_DATA_W-1:FRAME_W], fw});
    noise = $urandom;
    write_reg(REG_FRAME_HEIGHT, {noise[CFG_DATA_W-1:FRAME_W], fh});
    noise = $urandom;
    write_reg(REG_MIN_RADIUS, {noise[CFG_DATA_W-1:8], rmin});
    write_reg(REG_VOTE_THRESHOLD, thr);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(make_item(OP_VOTE, 128, 128, EDGE_ON));
    send_item(make_item(OP_VOTE, 128, 128, 254));
    send_item(make_item(OP_VOTE, 0, PIXEL_MAX, 0));
    send_item(make_item(OP_VOTE, PIXEL_MAX, 0, EDGE_ON));
    send_item(make_item(OP_REPORT, 78, 128, 0));
    send_item(make_item(OP_REPORT, 0, 0, EDGE_ON));
    send_item(make_item(OP_REPORT, PIXEL_MAX, PIXEL_MAX, 0));
  endtask

  // radius zero stacks every angle on the pixel itself
  task automatic test_small_radius();
    program_regs(9'd256, 9'd256, 8'd0, 16'd359);
    send_item(make_item(OP_VOTE, 10, 20, EDGE_ON));
    send_item(make_item(OP_REPORT, 10, 20, 0));
    program_regs(9'd256, 9'd256, 8'd0, 16'd360);
    send_item(make_item(OP_VOTE, 10, 20, EDGE_ON));
    send_item(make_item(OP_REPORT, 10, 20, 0));
    program_regs(9'd256, 9'd256, 8'd1, 16'd0);
    send_item(make_item(OP_VOTE, 3, 4, EDGE_ON));
    send_item(make_item(OP_REPORT, 2, 4, 0));
  endtask

  task automatic test_frame_limits();
    program_regs(9'd0, 9'd256, 8'd0, 16'd0);
    send_item(make_item(OP_VOTE, 40, 40, EDGE_ON));
    send_item(make_item(OP_REPORT, 40, 40, 0));
    program_regs(9'h1FF, 9'h1FF, 8'd255, 16'hFFFF);
    send_item(make_item(OP_VOTE, PIXEL_MAX, PIXEL_MAX, EDGE_ON));
    send_item(make_item(OP_REPORT, 0, PIXEL_MAX, 0));
    // pixel far outside a small frame still lands centers inside it
    program_regs(9'd16, 9'd16, 8'd200, 16'd0);
    send_item(make_item(OP_VOTE, 150, 150, EDGE_ON));
    send_item(make_item(OP_REPORT, 4, 4, 0));
  endtask

  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = HOLD_OFF_CYCLES;
    for (int n = 0; n < 6; n++) begin
      send_item(make_item(OP_REPORT, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, PIXEL_MAX)));
    end
  endtask

  task automatic test_random_traffic();
    int roll, sent, r, deg, a, b;
    logic [2*PIX_W-1:0] pick;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: program_regs(9'd256, 9'd256, 8'd1, 16'd0);
        1: program_regs(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                        8'($urandom_range(1, 255)), 16'($urandom_range(0, 3)));
        2: program_regs(9'd511, 9'd300, 8'd255, 16'd1);
        default: program_regs(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                              8'($urandom_range(0, 255)), 16'($urandom_range(0, 2)));
      endcase
      send_idle_pct  = IDLE_PLAN[p];
      recv_stall_pct = STALL_PLAN[p];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          send_item(make_item(OP_VOTE, $urandom_range(0, PIXEL_MAX),
                              $urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX - 1)));
        end else if (roll < 50) begin
          send_item(make_item(OP_VOTE, $urandom_range(0, PIXEL_MAX),
                              $urandom_range(0, PIXEL_MAX), EDGE_ON));
          sent++;
        end else if (roll < 90 && voted_pixels.size() != 0) begin
          // aim at a center that a recent edge pixel voted for
          pick = voted_pixels[$urandom_range(0, voted_pixels.size() - 1)];
          r    = int'(rmin_setting) + $urandom_range(0, RADIUS_COUNT - 1);
          deg  = $urandom_range(0, FULL_TURN - 1);
          a    = shift_center(int'(pick[2*PIX_W-1:PIX_W]), r, sine_of(deg + QUARTER_TURN));
          b    = shift_center(int'(pick[PIX_W-1:0]), r, sine_of(deg));
          a    = (a < 0) ? 0 : ((a > PIXEL_MAX) ? PIXEL_MAX : a);
          b    = (b < 0) ? 0 : ((b > PIXEL_MAX) ? PIXEL_MAX : b);
          send_item(make_item(OP_REPORT, a, b, $urandom_range(0, PIXEL_MAX)));
          sent++;
        end else begin
          send_item(make_item(OP_REPORT, $urandom_range(0, PIXEL_MAX),
                              $urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX)));
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (report_rows.size() == 0) begin
        $error("unexpected result center_x %0d center_y %0d radius %0d",
               out_data.center_x, out_data.center_y, out_data.radius);
        error_count++;
      end else begin
        head_row = report_rows.pop_front();
        check_field("center_x", head_row.center_x, out_data.center_x);
        check_field("center_y", head_row.center_y, out_data.center_y);
        check_field("radius", head_row.radius, out_data.radius);
        check_field("vote_count", head_row.vote_count, out_data.vote_count);
        check_field("found", head_row.found, out_data.found);
        check_field("last", head_row.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_hough_circle_voter failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_small_radius();
    test_frame_limits();
    test_output_hold_off();
    test_random_traffic();
    settle_block();
    if (error_count == 0) begin
      $display("tb_hough_circle_voter passed");
    end else begin
      $display("tb_hough_circle_voter failed");
    end
    $finish;
  end

endmodule
